### src/ihex_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the intel hex record loader
package ihex_pkg;

   // parser phase within a record
   typedef enum logic [2:0] {
      PH_COLON,
      PH_COUNT,
      PH_ADDR,
      PH_KIND,
      PH_DATA,
      PH_CHECK,
      PH_HALT
   } phase_type;

   // record types
   localparam logic [7:0] KIND_DATA = 8'h00;
   localparam logic [7:0] KIND_END  = 8'h01;

   // load status codes
   localparam logic [1:0] STATUS_RUNNING   = 2'd0;
   localparam logic [1:0] STATUS_END       = 2'd1;
   localparam logic [1:0] STATUS_BAD_KIND  = 2'd2;
   localparam logic [1:0] STATUS_NO_COLON  = 2'd3;

   // characters
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // digit counts that close a field
   localparam logic [1:0] BYTE_DIGITS = 2'd2;
   localparam logic [1:0] WORD_DIGITS = 2'd0;  // four digits wrap the 2-bit count

   // classification of one character
   typedef struct packed {
      logic       is_space;
      logic       is_colon;
      logic       bad;
      logic [3:0] value;
   } char_class_type;

endpackage

### src/ihex_if.sv
`timescale 1ns / 1ps
// channel interfaces of the intel hex record loader

interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [16:0] write_address;
   logic [7:0]  write_data;
   logic        bad_digit;
   logic [1:0]  load_status;

   modport source (output valid, output write_valid, output write_address,
                   output write_data, output bad_digit, output load_status,
                   input ready);
   modport sink   (input valid, input write_valid, input write_address,
                   input write_data, input bad_digit, input load_status,
                   output ready);
endinterface

### src/intel_hex_record_loader.sv
`timescale 1ns / 1ps
// top level of the intel hex record loader
//
// Takes one ASCII character per req transaction and returns exactly one rsp
// transaction per character, in order. A character is held in the input register
// and is then parsed in a single pass into the result register, and one character
// can be accepted every cycle; the rate is set only by the rsp side taking results.
// Whitespace is skipped, data bytes appear as write_valid with write_address =
// record address + byte index, the checksum is consumed unchecked, non-hex digits
// count as zero and raise bad_digit, and load_status becomes nonzero (end record,
// unknown type, missing colon); once the parser halts, after that record's checksum
// or at once for a missing colon, every further character yields only the status.
module intel_hex_record_loader (
   input  logic       clock,
   input  logic       reset,
   ihex_req_if.sink   req_if,
   ihex_rsp_if.source rsp_if
);

   logic                     in_valid_ff;
   logic [7:0]               in_ch_ff;
   logic                     can_step;
   logic                     step;
   ihex_pkg::char_class_type cls;

   // input register moves on when the result register can take it
   assign step         = in_valid_ff && can_step;
   assign req_if.ready = !in_valid_ff || can_step;

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_ch_ff <= req_if.ch;
      end
   end

   ihex_decode u_decode (
      .ch  (in_ch_ff),
      .cls (cls)
   );

   ihex_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .cls      (cls),
      .can_step (can_step),
      .rsp      (rsp_if)
   );

endmodule

### src/ihex_decode.sv
`timescale 1ns / 1ps
// character classifier: whitespace, colon and hex digit value
module ihex_decode (
   input  logic [7:0]              ch,
   output ihex_pkg::char_class_type cls
);

   logic is_dec;
   logic is_upper;
   logic is_lower;
   logic [7:0] diff;

   // digit ranges
   assign is_dec   = (ch >= 8'h30) && (ch <= 8'h39);
   assign is_upper = (ch >= 8'h41) && (ch <= 8'h46);
   assign is_lower = (ch >= 8'h61) && (ch <= 8'h66);

   // value of a letter digit is its offset from 'a' or 'A' plus ten
   always_comb begin
      diff = 8'd0;
      if (is_dec) begin
         diff = ch - 8'h30;
      end else if (is_upper) begin
         diff = ch - 8'h37;
      end else if (is_lower) begin
         diff = ch - 8'h57;
      end
   end

   // pack the classification
   always_comb begin
      cls.is_space = ((ch >= ihex_pkg::CHAR_TAB) && (ch <= ihex_pkg::CHAR_CR))
                     || (ch == ihex_pkg::CHAR_SPACE);
      cls.is_colon = (ch == ihex_pkg::CHAR_COLON);
      cls.bad      = !(is_dec || is_upper || is_lower);
      cls.value    = diff[3:0];
   end

endmodule

### src/ihex_parser.sv
`timescale 1ns / 1ps
// record parser state and registered result transaction
module ihex_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  ihex_pkg::char_class_type cls,
   output logic                     can_step,
   ihex_rsp_if.source               rsp
);

   ihex_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] address_ff, address_in;
   logic [7:0]  index_ff, index_in;
   logic [1:0]  status_ff, status_in;

   logic        out_valid_ff;
   logic        wv_ff, wv_in;
   logic [16:0] wa_ff, wa_in;
   logic [7:0]  wd_ff, wd_in;
   logic        bd_ff, bd_in;

   logic        active;
   logic        is_digit_pos;
   logic [15:0] acc_shift;
   logic [1:0]  count_inc;
   logic        byte_done;
   logic        word_done;
   logic [7:0]  index_inc;
   logic [7:0]  kind;

   // result register frees when empty or taken
   assign can_step = !out_valid_ff || rsp.ready;

   // shared digit shifter
   assign active       = (phase_ff != ihex_pkg::PH_HALT) && !cls.is_space;
   assign is_digit_pos = active && (phase_ff != ihex_pkg::PH_COLON);
   assign acc_shift    = {acc_ff[11:0], cls.value};
   assign count_inc    = digit_count_ff + 2'd1;
   assign byte_done    = (count_inc == ihex_pkg::BYTE_DIGITS);
   assign word_done    = (count_inc == ihex_pkg::WORD_DIGITS);
   assign index_inc    = index_ff + 8'd1;
   assign kind         = acc_shift[7:0];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         unique case (phase_ff)
            ihex_pkg::PH_COLON:
               phase_in = cls.is_colon ? ihex_pkg::PH_COUNT : ihex_pkg::PH_HALT;
            ihex_pkg::PH_COUNT:
               if (byte_done) phase_in = ihex_pkg::PH_ADDR;
            ihex_pkg::PH_ADDR:
               if (word_done) phase_in = ihex_pkg::PH_KIND;
            ihex_pkg::PH_KIND:
               if (byte_done) begin
                  if ((kind == ihex_pkg::KIND_DATA) && (length_ff != 8'd0)) begin
                     phase_in = ihex_pkg::PH_DATA;
                  end else begin
                     phase_in = ihex_pkg::PH_CHECK;
                  end
               end
            ihex_pkg::PH_DATA:
               if (byte_done && (index_inc >= length_ff)) phase_in = ihex_pkg::PH_CHECK;
            ihex_pkg::PH_CHECK:
               if (byte_done) begin
                  phase_in = (status_ff != ihex_pkg::STATUS_RUNNING)
                             ? ihex_pkg::PH_HALT : ihex_pkg::PH_COLON;
               end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // datapath and result fields
   always_comb begin
      digit_count_in = digit_count_ff;
      acc_in         = acc_ff;
      length_in      = length_ff;
      address_in     = address_ff;
      index_in       = index_ff;
      status_in      = status_ff;
      wv_in          = 1'b0;
      wa_in          = 17'd0;
      wd_in          = 8'd0;
      bd_in          = is_digit_pos && cls.bad;
      if (is_digit_pos) begin
         acc_in         = acc_shift;
         digit_count_in = count_inc;
      end
      if (active) begin
         unique case (phase_ff)
            ihex_pkg::PH_COLON:
               if (cls.is_colon) begin
                  digit_count_in = 2'd0;
                  acc_in         = 16'd0;
               end else begin
                  status_in = ihex_pkg::STATUS_NO_COLON;
               end
            ihex_pkg::PH_COUNT:
               if (byte_done) begin
                  digit_count_in = 2'd0;
                  length_in      = acc_shift[7:0];
               end
            ihex_pkg::PH_ADDR:
               if (word_done) begin
                  digit_count_in = 2'd0;
                  address_in     = acc_shift;
               end
            ihex_pkg::PH_KIND:
               if (byte_done) begin
                  digit_count_in = 2'd0;
                  index_in       = 8'd0;
                  if (kind == ihex_pkg::KIND_END) begin
                     status_in = ihex_pkg::STATUS_END;
                  end else if (kind != ihex_pkg::KIND_DATA) begin
                     status_in = ihex_pkg::STATUS_BAD_KIND;
                  end
               end
            ihex_pkg::PH_DATA:
               if (byte_done) begin
                  digit_count_in = 2'd0;
                  wv_in          = 1'b1;
                  wa_in          = {1'b0, address_ff} + {9'd0, index_ff};
                  wd_in          = acc_shift[7:0];
                  index_in       = index_inc;
               end
            ihex_pkg::PH_CHECK:
               if (byte_done) digit_count_in = 2'd0;
            default: digit_count_in = digit_count_ff;
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ihex_pkg::PH_COLON;
         digit_count_ff <= 2'd0;
         acc_ff         <= 16'd0;
         length_ff      <= 8'd0;
         address_ff     <= 16'd0;
         index_ff       <= 8'd0;
         status_ff      <= ihex_pkg::STATUS_RUNNING;
      end else if (step) begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         acc_ff         <= acc_in;
         length_ff      <= length_in;
         address_ff     <= address_in;
         index_ff       <= index_in;
         status_ff      <= status_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step) begin
         wv_ff <= wv_in;
         wa_ff <= wa_in;
         wd_ff <= wd_in;
         bd_ff <= bd_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.write_valid   = wv_ff;
   assign rsp.write_address = wa_ff;
   assign rsp.write_data    = wd_ff;
   assign rsp.bad_digit     = bd_ff;
   assign rsp.load_status   = status_ff;

endmodule

### tb/ihex_loader_checker.sv
`timescale 1ns / 1ps
// checker of the intel hex record loader: predicts each load result and compares
module ihex_loader_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_write_valid,
   input  logic [16:0] rsp_write_address,
   input  logic [7:0]  rsp_write_data,
   input  logic        rsp_bad_digit,
   input  logic [1:0]  rsp_load_status,
   output int          results_due,
   output int          mismatches
);

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic        write_valid;
      logic [16:0] write_address;
      logic [7:0]  write_data;
      logic        bad_digit;
      logic [1:0]  load_status;
   } load_result_type;

   // parser copy, one character at a time
   ihex_pkg::phase_type parse_phase;
   logic [1:0]  digits_seen;
   logic [15:0] field_value;
   logic [7:0]  rec_length;
   logic [15:0] rec_address;
   logic [7:0]  rec_kind;
   logic [7:0]  rec_index;
   logic [1:0]  load_state;

   load_result_type due_results[$];

   task automatic clear_parser();
      parse_phase = ihex_pkg::PH_COLON;
      digits_seen = '0;
      field_value = '0;
      rec_length  = '0;
      rec_address = '0;
      rec_kind    = '0;
      rec_index   = '0;
      load_state  = ihex_pkg::STATUS_RUNNING;
   endtask

   // {bad, value}: non-hex characters read as zero
   function automatic logic [4:0] decode_hex(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b0, c[3:0]};
      end
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
         return {1'b0, c[3:0] + 4'd9};
      end
      return 5'b1_0000;
   endfunction

   // advance the parser by one character and form its result
   task automatic parse_char(input logic [7:0] c, output load_result_type r);
      logic [3:0] nibble;
      logic       bad;
      logic       field_done;
      r = '0;
      if (parse_phase != ihex_pkg::PH_HALT &&
          !(c inside {[8'd9:8'd13], ihex_pkg::CHAR_SPACE})) begin
         if (parse_phase == ihex_pkg::PH_COLON) begin
            if (c == ihex_pkg::CHAR_COLON) begin
               parse_phase = ihex_pkg::PH_COUNT;
               digits_seen = '0;
               field_value = '0;
            end else begin
               load_state  = ihex_pkg::STATUS_NO_COLON;
               parse_phase = ihex_pkg::PH_HALT;
            end
         end else begin
            {bad, nibble} = decode_hex(c);
            r.bad_digit = bad;
            field_value = {field_value[11:0], nibble};
            digits_seen = digits_seen + 2'd1;
            field_done  = (digits_seen ==
                           ((parse_phase == ihex_pkg::PH_ADDR) ? ihex_pkg::WORD_DIGITS
                                                               : ihex_pkg::BYTE_DIGITS));
            if (field_done) begin
               digits_seen = '0;
               case (parse_phase)
                  ihex_pkg::PH_COUNT: begin
                     rec_length  = field_value[7:0];
                     parse_phase = ihex_pkg::PH_ADDR;
                  end
                  ihex_pkg::PH_ADDR: begin
                     rec_address = field_value;
                     parse_phase = ihex_pkg::PH_KIND;
                  end
                  ihex_pkg::PH_KIND: begin
                     rec_kind  = field_value[7:0];
                     rec_index = '0;
                     if (rec_kind == ihex_pkg::KIND_DATA) begin
                        parse_phase = (rec_length == 8'd0) ? ihex_pkg::PH_CHECK
                                                           : ihex_pkg::PH_DATA;
                     end else begin
                        load_state  = (rec_kind == ihex_pkg::KIND_END)
                                      ? ihex_pkg::STATUS_END : ihex_pkg::STATUS_BAD_KIND;
                        parse_phase = ihex_pkg::PH_CHECK;
                     end
                  end
                  ihex_pkg::PH_DATA: begin
                     r.write_valid   = 1'b1;
                     r.write_address = {1'b0, rec_address} + {9'd0, rec_index};
                     r.write_data    = field_value[7:0];
                     rec_index       = rec_index + 8'd1;
                     if (rec_index >= rec_length) parse_phase = ihex_pkg::PH_CHECK;
                  end
                  default: begin
                     parse_phase = (load_state != ihex_pkg::STATUS_RUNNING)
                                   ? ihex_pkg::PH_HALT : ihex_pkg::PH_COLON;
                  end
               endcase
            end
         end
      end
      r.load_status = load_state;
   endtask

   task automatic report_mismatch(input string what, input logic [16:0] got,
                                  input logic [16:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   // watch both channels at every edge
   always @(posedge clock) begin
      load_result_type seen;
      load_result_type want;
      if (reset) begin
         clear_parser();
         due_results.delete();
         mismatches = 0;
      end else begin
         // result transaction against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_write_valid, rsp_write_address, rsp_write_data,
                    rsp_bad_digit, rsp_load_status};
            if (due_results.size() == 0) begin
               report_mismatch("unexpected result", 17'(seen), 17'd0);
            end else begin
               want = due_results.pop_front();
               if (seen.write_valid !== want.write_valid)
                  report_mismatch("write_valid", 17'(seen.write_valid),
                                  17'(want.write_valid));
               if (seen.write_address !== want.write_address)
                  report_mismatch("write_address", seen.write_address, want.write_address);
               if (seen.write_data !== want.write_data)
                  report_mismatch("write_data", 17'(seen.write_data), 17'(want.write_data));
               if (seen.bad_digit !== want.bad_digit)
                  report_mismatch("bad_digit", 17'(seen.bad_digit), 17'(want.bad_digit));
               if (seen.load_status !== want.load_status)
                  report_mismatch("load_status", 17'(seen.load_status),
                                  17'(want.load_status));
            end
         end
         // character transaction
         if (req_valid && req_ready) begin
            parse_char(req_ch, want);
            due_results.push_back(want);
         end
      end
      results_due <= due_results.size();
   end

endmodule

### tb/tb_intel_hex_record_loader.sv
`timescale 1ns / 1ps
// testbench top of the intel hex record loader: character stimulus and verdict
module tb_intel_hex_record_loader;

   localparam int ITEM_TARGET   = 1700;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;

   logic clock;
   logic reset;
   int   results_due;
   int   mismatches;
   int   chars_sent;
   int   sender_streak;
   int   receiver_streak;
   int   cycle_count;

   ihex_req_if req_if ();
   ihex_rsp_if rsp_if ();

   intel_hex_record_loader dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ihex_loader_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_if.valid),
      .req_ready         (req_if.ready),
      .req_ch            (req_if.ch),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_write_valid   (rsp_if.write_valid),
      .rsp_write_address (rsp_if.write_address),
      .rsp_write_data    (rsp_if.write_data),
      .rsp_bad_digit     (rsp_if.bad_digit),
      .rsp_load_status   (rsp_if.load_status),
      .results_due       (results_due),
      .mismatches        (mismatches)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // wait cycles before a transaction, with occasional stretches of none
   function automatic int draw_idle(inout int streak);
      if (streak > 0) begin
         streak--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         streak = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // one character transaction
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = draw_idle(sender_streak);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ch    <= c;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (!(c inside {[8'd9:8'd13], ihex_pkg::CHAR_SPACE})) chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_char(s[k]);
   endtask

   // occasional whitespace between characters
   task automatic maybe_blank();
      int k;
      if ($urandom_range(0, 9) == 0) begin
         k = $urandom_range(8, 13);
         send_char((k == 8) ? ihex_pkg::CHAR_SPACE : 8'(k));
      end
   endtask

   // any non-whitespace character that is not a hex digit
   function automatic logic [7:0] pick_bad_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while ((c inside {[8'd9:8'd13], ihex_pkg::CHAR_SPACE}) ||
                 (c >= "0" && c <= "9") ||
                 (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
      return c;
   endfunction

   // a zero digit may go out as a non-hex character, which reads the same
   task automatic send_digit(input logic [3:0] v);
      logic [7:0] c;
      if (v == 4'd0 && $urandom_range(0, 5) == 0) begin
         c = pick_bad_char();
      end else if (v < 4'd10) begin
         c = 8'h30 + 8'(v);
      end else begin
         c = (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
      end
      send_char(c);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_digit(b[7:4]);
      maybe_blank();
      send_digit(b[3:0]);
      maybe_blank();
   endtask

   // well-formed record with random data and a true checksum
   task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                              input logic [7:0] kind);
      logic [7:0] sum;
      logic [7:0] data;
      int         pick;
      sum = len + addr[15:8] + addr[7:0] + kind;
      send_char(ihex_pkg::CHAR_COLON);
      maybe_blank();
      send_byte(len);
      send_byte(addr[15:8]);
      send_byte(addr[7:0]);
      send_byte(kind);
      if (kind == ihex_pkg::KIND_DATA) begin
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            sum += data;
            send_byte(data);
         end
      end
      send_byte(8'h00 - sum);
   endtask

   task automatic send_random_record();
      logic [7:0]  len;
      logic [15:0] addr;
      int          pick;
      pick = $urandom_range(0, 49);
      if (pick == 0) len = 8'hFF;
      else if (pick <= 3) len = 8'($urandom_range(17, 254));
      else len = 8'($urandom_range(0, 16));
      if ($urandom_range(0, 7) == 0) addr = 16'($urandom_range(16'hFF00, 16'hFFFF));
      else addr = 16'($urandom_range(0, 16'hFFFF));
      send_record(len, addr, ihex_pkg::KIND_DATA);
   endtask

   // stop sending until every predicted result has come back
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   // result side: random stalls before each transaction
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      receiver_streak = 0;
      forever begin
         gap = draw_idle(receiver_streak);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("intel_hex_record_loader regression: fail");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int terminal;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.ch    <= '0;
      chars_sent    = 0;
      sender_streak = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every whitespace code before the first record
      for (int k = 9; k <= 13; k++) send_char(8'(k));
      send_char(ihex_pkg::CHAR_SPACE);
      // two bytes at the top of the address range, mixed case, colon as checksum digit
      send_text(":02ffFF00\t00Ff0:");
      // non-hex characters in address, data and checksum positions
      send_text(":01zz0000g7");
      send_char(8'h80);
      send_char(8'hFF);
      wait_for_results();

      // longest record at the highest address, then random records
      send_record(8'hFF, 16'hFFFF, ihex_pkg::KIND_DATA);
      while (chars_sent < ITEM_TARGET) begin
         send_random_record();
         if ($urandom_range(0, 11) == 0) wait_for_results();
      end

      // one way of stopping: end record, unknown type or missing colon
      terminal = $urandom_range(0, 2);
      case (terminal)
         0: send_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)),
                        ihex_pkg::KIND_END);
         1: send_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)),
                        8'($urandom_range(2, 255)));
         default: begin
            send_char(($urandom_range(0, 1) == 1) ? pick_bad_char() : "0");
         end
      endcase
      // halted: later characters carry only the status
      repeat (16) send_char(8'($urandom_range(0, 255)));

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("intel_hex_record_loader regression: pass");
      end else begin
         $display("intel_hex_record_loader regression: fail");
      end
      $finish;
   end

endmodule
